FILE: rtl/wswc_pkg.sv
package wswc_pkg;

   localparam int WINDOW_MAX = 256;
   localparam int ADDR_BITS  = 32;
   localparam int PAGE_W     = ADDR_BITS;
   localparam int SHIFT_W    = 5;
   localparam int CNT_W      = 9;
   localparam int SUM_W      = 40;
   localparam int TALLY_W    = 32;
   localparam int CSR_DATA_W = 9;

   localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RESET    = SHIFT_W'(12);
   localparam logic [CNT_W-1:0]   WINDOW_LENGTH_RESET = CNT_W'(16);
   localparam logic [CNT_W-1:0]   NO_FULL_WINDOW      = CNT_W'(257);
   localparam logic [CNT_W-1:0]   WINDOW_MAX_CNT      = CNT_W'(WINDOW_MAX);
   localparam logic [SUM_W-1:0]   SUM_MAX             = '1;
   localparam logic [TALLY_W-1:0] TALLY_MAX           = '1;

   typedef enum logic {
      CSR_PAGE_SHIFT    = 1'b0,
      CSR_WINDOW_LENGTH = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_COMMIT
   } state_type;

   // Control broadcast to every cell of the page chain.
   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctl_type;

   // Statistics produced for one committed access.
   typedef struct packed {
      logic               window_closed;
      logic [CNT_W-1:0]   distinct_pages;
      logic [CNT_W-1:0]   fewest_pages;
      logic [CNT_W-1:0]   most_pages;
      logic [SUM_W-1:0]   frames_sum;
      logic [TALLY_W-1:0] window_tally;
   } stats_type;

endpackage

FILE: rtl/wswc_if.sv
interface wswc_req_if;
   logic                         valid;
   logic                         ready;
   logic [wswc_pkg::PAGE_W-1:0]  address;
   logic                         last_of_trace;

   modport source (output valid, output address, output last_of_trace, input ready);
   modport sink (input valid, input address, input last_of_trace, output ready);
endinterface

interface wswc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [wswc_pkg::PAGE_W-1:0]   page_number;
   logic                          window_closed;
   logic                          trace_closed;
   logic [wswc_pkg::CNT_W-1:0]    distinct_pages;
   logic [wswc_pkg::CNT_W-1:0]    fewest_pages;
   logic [wswc_pkg::CNT_W-1:0]    most_pages;
   logic [wswc_pkg::SUM_W-1:0]    frames_sum;
   logic [wswc_pkg::TALLY_W-1:0]  window_tally;

   modport source (output valid, output page_number, output window_closed,
                   output trace_closed, output distinct_pages, output fewest_pages,
                   output most_pages, output frames_sum, output window_tally,
                   input ready);
   modport sink (input valid, input page_number, input window_closed,
                 input trace_closed, input distinct_pages, input fewest_pages,
                 input most_pages, input frames_sum, input window_tally,
                 output ready);
endinterface

FILE: rtl/working_set_window_counter.sv
// Working-set window counter. Each request beat carries one 32-bit access
// address; the block returns one response beat per request with the page
// number (address shifted right by page_shift), the distinct page count of
// the current window including this access, and the running statistics.
// Every access passes through three steps: the page number is formed as
// the request is taken, then all 256 cells of the page chain compare their
// stored page with it in parallel, and then the hits are reduced, a new
// page is pushed into the chain and the statistics are updated. The next
// request is taken only once the last access has committed and the block
// is at rest; a waiting response beat holds off the next commit, not the next request.
// Configuration must be written only while the block is idle.
module working_set_window_counter (
   input  logic                              clock,
   input  logic                              reset,
   wswc_req_if.sink                          req_ch,
   wswc_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  wswc_pkg::csr_index_type           csr_index,
   input  logic [wswc_pkg::CSR_DATA_W-1:0]   csr_data
);

   // Configuration registers.
   logic [wswc_pkg::SHIFT_W-1:0] page_shift_ff;
   logic [wswc_pkg::CNT_W-1:0]   window_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_shift_ff    <= wswc_pkg::PAGE_SHIFT_RESET;
         window_length_ff <= wswc_pkg::WINDOW_LENGTH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            wswc_pkg::CSR_PAGE_SHIFT: begin
               page_shift_ff <= csr_data[wswc_pkg::SHIFT_W-1:0];
            end
            wswc_pkg::CSR_WINDOW_LENGTH: begin
               window_length_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Sequencer.
   wswc_pkg::state_type state_ff, state_in;
   logic req_fire;
   logic out_free;
   logic commit;
   logic rsp_valid_ff;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wswc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_ch.ready = 1'b0;
      commit       = 1'b0;
      unique case (state_ff)
         wswc_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               state_in = wswc_pkg::ST_COMPARE;
            end
         end
         wswc_pkg::ST_COMPARE: begin
            state_in = wswc_pkg::ST_COMMIT;
         end
         wswc_pkg::ST_COMMIT: begin
            // Hold here while the previous response beat is still unclaimed.
            if (out_free) begin
               commit   = 1'b1;
               state_in = wswc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wswc_pkg::ST_IDLE;
         end
      endcase
   end

   // Page number and trace marker of the access in flight.
   logic [wswc_pkg::PAGE_W-1:0] page_ff;
   logic                        last_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         page_ff <= req_ch.address >> page_shift_ff;
         last_ff <= req_ch.last_of_trace;
      end
   end

   // Page chain: new pages enter at cell zero and the rest move one place on.
   // Cells are only ever filled from the front, so the chain stays packed.
   logic [wswc_pkg::PAGE_W-1:0]     cell_page [wswc_pkg::WINDOW_MAX];
   logic [wswc_pkg::WINDOW_MAX-1:0] cell_valid;
   logic [wswc_pkg::WINDOW_MAX-1:0] cell_hit;
   wswc_pkg::cell_ctl_type          cell_ctl;
   logic                            insert;
   logic                            clear_set;
   logic                            found;
   logic [wswc_pkg::CNT_W-1:0]      occupied;
   wswc_pkg::stats_type             stats;

   assign found          = |cell_hit;
   assign cell_ctl.shift = commit && insert;
   assign cell_ctl.clear = clear_set;

   for (genvar i = 0; i < wswc_pkg::WINDOW_MAX; i++) begin : g_cell
      if (i == 0) begin : g_head
         wswc_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (cell_ctl),
            .key        (page_ff),
            .prev_page  (page_ff),
            .prev_valid (1'b1),
            .page       (cell_page[i]),
            .valid      (cell_valid[i]),
            .hit        (cell_hit[i])
         );
      end else begin : g_body
         wswc_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (cell_ctl),
            .key        (page_ff),
            .prev_page  (cell_page[i-1]),
            .prev_valid (cell_valid[i-1]),
            .page       (cell_page[i]),
            .valid      (cell_valid[i]),
            .hit        (cell_hit[i])
         );
      end
   end

   wswc_stats u_stats (
      .clock         (clock),
      .reset         (reset),
      .commit        (commit),
      .found         (found),
      .last          (last_ff),
      .window_length (window_length_ff),
      .insert        (insert),
      .clear_set     (clear_set),
      .occupied      (occupied),
      .stats         (stats)
   );

   // Response register.
   logic [wswc_pkg::PAGE_W-1:0] rsp_page_ff;
   logic                        rsp_last_ff;
   wswc_pkg::stats_type         rsp_stats_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_page_ff  <= page_ff;
         rsp_last_ff  <= last_ff;
         rsp_stats_ff <= stats;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.page_number    = rsp_page_ff;
   assign rsp_ch.window_closed  = rsp_stats_ff.window_closed;
   assign rsp_ch.trace_closed   = rsp_last_ff;
   assign rsp_ch.distinct_pages = rsp_stats_ff.distinct_pages;
   assign rsp_ch.fewest_pages   = rsp_stats_ff.fewest_pages;
   assign rsp_ch.most_pages     = rsp_stats_ff.most_pages;
   assign rsp_ch.frames_sum     = rsp_stats_ff.frames_sum;
   assign rsp_ch.window_tally   = rsp_stats_ff.window_tally;

   // A response beat only appears after a commit.
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == wswc_pkg::ST_COMMIT))
      else $error("response raised without a commit");

   // The set can never hold more pages than the chain has cells.
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      occupied <= wswc_pkg::WINDOW_MAX_CNT)
      else $error("set occupancy beyond chain length");

   // A closing full window lies between the reported minimum and maximum.
   a_window_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stats_ff.window_closed |->
         rsp_stats_ff.most_pages >= rsp_stats_ff.distinct_pages &&
         rsp_stats_ff.fewest_pages <= rsp_stats_ff.distinct_pages)
      else $error("closed window outside min/max bounds");

   // The head of the chain is packed: cell one is never valid while cell zero is empty.
   a_chain_packed: assert property (@(posedge clock) disable iff (reset)
      cell_valid[1] |-> cell_valid[0])
      else $error("page chain has a hole at its head");

endmodule

FILE: rtl/wswc_cell.sv
// One entry of the page set: holds a page, compares it with the key and
// passes its contents to the next cell when a new page is pushed in.
module wswc_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  wswc_pkg::cell_ctl_type       ctl,
   input  logic [wswc_pkg::PAGE_W-1:0]  key,
   input  logic [wswc_pkg::PAGE_W-1:0]  prev_page,
   input  logic                         prev_valid,
   output logic [wswc_pkg::PAGE_W-1:0]  page,
   output logic                         valid,
   output logic                         hit
);

   logic [wswc_pkg::PAGE_W-1:0] page_ff;
   logic                        valid_ff;
   logic                        hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         hit_ff <= valid_ff && (page_ff == key);
         if (ctl.clear) begin
            valid_ff <= 1'b0;
         end else if (ctl.shift) begin
            valid_ff <= prev_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         page_ff <= prev_page;
      end
   end

   assign page  = page_ff;
   assign valid = valid_ff;
   assign hit   = hit_ff;

endmodule

FILE: rtl/wswc_stats.sv
// Window bookkeeping: set occupancy, access count, min/max and the
// saturating totals. State moves only on a commit.
module wswc_stats (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          commit,
   input  logic                          found,
   input  logic                          last,
   input  logic [wswc_pkg::CNT_W-1:0]    window_length,
   output logic                          insert,
   output logic                          clear_set,
   output logic [wswc_pkg::CNT_W-1:0]    occupied,
   output wswc_pkg::stats_type           stats
);

   logic [wswc_pkg::CNT_W-1:0]   occupied_ff, occupied_in;
   logic [wswc_pkg::CNT_W-1:0]   access_ff, access_in;
   logic [wswc_pkg::CNT_W-1:0]   fewest_ff, fewest_in;
   logic [wswc_pkg::CNT_W-1:0]   most_ff, most_in;
   logic [wswc_pkg::SUM_W-1:0]   frames_ff, frames_in;
   logic [wswc_pkg::TALLY_W-1:0] tally_ff, tally_in;

   logic [wswc_pkg::CNT_W-1:0]   len;
   logic [wswc_pkg::CNT_W-1:0]   occ_next;
   logic [wswc_pkg::CNT_W-1:0]   acc_next;
   logic [wswc_pkg::CNT_W-1:0]   fewest_next;
   logic [wswc_pkg::CNT_W-1:0]   most_next;
   logic [wswc_pkg::SUM_W-1:0]   frames_next;
   logic [wswc_pkg::TALLY_W-1:0] tally_next;
   logic [wswc_pkg::SUM_W:0]     sum_wide;
   logic                         wclosed;
   logic                         add;

   always_comb begin
      if (window_length == '0 || window_length > wswc_pkg::WINDOW_MAX_CNT) begin
         len = wswc_pkg::WINDOW_MAX_CNT;
      end else begin
         len = window_length;
      end

      insert   = !found && (occupied_ff < wswc_pkg::WINDOW_MAX_CNT);
      occ_next = occupied_ff + wswc_pkg::CNT_W'(insert);
      acc_next = access_ff + wswc_pkg::CNT_W'(1);
      wclosed  = (acc_next >= len);
      add      = wclosed || last;

      fewest_next = (wclosed && occ_next < fewest_ff) ? occ_next : fewest_ff;
      most_next   = (wclosed && occ_next > most_ff) ? occ_next : most_ff;

      sum_wide = {1'b0, frames_ff} + (wswc_pkg::SUM_W + 1)'(occ_next);
      if (!add) begin
         frames_next = frames_ff;
      end else if (sum_wide[wswc_pkg::SUM_W]) begin
         frames_next = wswc_pkg::SUM_MAX;
      end else begin
         frames_next = sum_wide[wswc_pkg::SUM_W-1:0];
      end
      tally_next = (add && tally_ff != wswc_pkg::TALLY_MAX)
                   ? tally_ff + wswc_pkg::TALLY_W'(1) : tally_ff;

      clear_set = commit && add;

      if (last) begin
         occupied_in = '0;
         access_in   = '0;
         fewest_in   = wswc_pkg::NO_FULL_WINDOW;
         most_in     = '0;
         frames_in   = '0;
         tally_in    = '0;
      end else begin
         occupied_in = wclosed ? '0 : occ_next;
         access_in   = wclosed ? '0 : acc_next;
         fewest_in   = fewest_next;
         most_in     = most_next;
         frames_in   = frames_next;
         tally_in    = tally_next;
      end

      stats.window_closed  = wclosed;
      stats.distinct_pages = occ_next;
      stats.fewest_pages   = fewest_next;
      stats.most_pages     = most_next;
      stats.frames_sum     = frames_next;
      stats.window_tally   = tally_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupied_ff <= '0;
         access_ff   <= '0;
         fewest_ff   <= wswc_pkg::NO_FULL_WINDOW;
         most_ff     <= '0;
         frames_ff   <= '0;
         tally_ff    <= '0;
      end else if (commit) begin
         occupied_ff <= occupied_in;
         access_ff   <= access_in;
         fewest_ff   <= fewest_in;
         most_ff     <= most_in;
         frames_ff   <= frames_in;
         tally_ff    <= tally_in;
      end
   end

   assign occupied = occupied_ff;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

// Testbench for the working-set window counter.
//
// A short table of directed beats comes first. The rows that can be worked out by eye
// carry their expected response. Every other row, and the random traffic after it, is
// checked against a model of the page set and the window statistics kept here.
//
// Request beats are driven with nonblocking assignments on the rising edge. A beat is
// taken at the edge where valid and ready are both high. The sender looks at ready on
// the falling edge before it, so it knows in good time that the beat will go. The
// response side is sampled on the rising edge, and it drives ready from the same
// process.
module testbench;
   import wswc_pkg::*;

   localparam int    LIMIT_NS     = 5_000_000;
   localparam int    QUIET_FROM   = 300;
   localparam int    QUIET_UNTIL  = 480;
   localparam int    RANDOM_BEATS = 800;
   localparam int    MAX_REPORTS  = 10;

   // One response beat, field by field, in the order the block presents them.
   typedef struct packed {
      logic [PAGE_W-1:0]  page_number;
      logic               window_closed;
      logic               trace_closed;
      logic [CNT_W-1:0]   distinct_pages;
      logic [CNT_W-1:0]   fewest_pages;
      logic [CNT_W-1:0]   most_pages;
      logic [SUM_W-1:0]   frames_sum;
      logic [TALLY_W-1:0] window_tally;
   } window_report_type;

   typedef enum logic [1:0] {
      ROW_CSR,
      ROW_ACCESS,
      ROW_ACCESS_TYPED
   } row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      csr_index_type     index;
      logic [CNT_W-1:0]  data;
      logic [PAGE_W-1:0] address;
      logic              last;
      window_report_type want;
   } plan_row_type;

   localparam int PLAN_ROWS = 28;

   // The directed table. Typed rows show the expected response as it follows straight
   // from the rules. Plain rows leave that field zero and are checked by the model.
   localparam plan_row_type DIRECTED_PLAN [PLAN_ROWS] = '{
      // Straight after reset: page shift 12 and windows of 16 beats.
      '{ROW_ACCESS_TYPED, CSR_PAGE_SHIFT, 9'd0, 32'h0000_0000, 1'b0,
        '{32'h0000_0000, 1'b0, 1'b0, 9'd1, 9'd257, 9'd0, 40'd0, 32'd0}},
      // The top address ends the trace in a partial window. It adds to the sum and to
      // the tally, but not to the fewest or most counts.
      '{ROW_ACCESS_TYPED, CSR_PAGE_SHIFT, 9'd0, 32'hFFFF_FFFF, 1'b1,
        '{32'h000F_FFFF, 1'b0, 1'b1, 9'd2, 9'd257, 9'd0, 40'd2, 32'd1}},
      // No shift and windows of one beat: every beat closes a full window.
      '{ROW_CSR, CSR_PAGE_SHIFT,    9'd0, 32'h0, 1'b0, '0},
      '{ROW_CSR, CSR_WINDOW_LENGTH, 9'd1, 32'h0, 1'b0, '0},
      '{ROW_ACCESS_TYPED, CSR_PAGE_SHIFT, 9'd0, 32'hFFFF_FFFF, 1'b0,
        '{32'hFFFF_FFFF, 1'b1, 1'b0, 9'd1, 9'd1, 9'd1, 40'd1, 32'd1}},
      // The last beat of the trace also fills a window, so that window is counted once,
      // as a full one.
      '{ROW_ACCESS_TYPED, CSR_PAGE_SHIFT, 9'd0, 32'h0000_0000, 1'b1,
        '{32'h0000_0000, 1'b1, 1'b1, 9'd1, 9'd1, 9'd1, 40'd2, 32'd2}},
      // Widest shift. A window length of zero stands for the longest window.
      '{ROW_CSR, CSR_PAGE_SHIFT,    9'd31, 32'h0, 1'b0, '0},
      '{ROW_CSR, CSR_WINDOW_LENGTH, 9'd0,  32'h0, 1'b0, '0},
      '{ROW_ACCESS, CSR_PAGE_SHIFT, 9'd0, 32'h8000_0000, 1'b0, '0},
      '{ROW_ACCESS, CSR_PAGE_SHIFT, 9'd0, 32'h7FFF_FFFF, 1'b0, '0},
      '{ROW_ACCESS, CSR_PAGE_SHIFT, 9'd0, 32'hFFFF_FFFF, 1'b1, '0},
      // A length above the longest window is also treated as the longest window.
      '{ROW_CSR, CSR_WINDOW_LENGTH, 9'd511, 32'h0, 1'b0, '0},
      '{ROW_CSR, CSR_PAGE_SHIFT,    9'd4,   32'h0, 1'b0, '0},
      '{ROW_ACCESS, CSR_PAGE_SHIFT, 9'd0, 32'h0000_0010, 1'b0, '0},
      '{ROW_ACCESS, CSR_PAGE_SHIFT, 9'd0, 32'h0000_001F, 1'b0, '0},
      '{ROW_ACCESS, CSR_PAGE_SHIFT, 9'd0, 32'h0000_0020, 1'b0, '0},
      '{ROW_ACCESS, CSR_PAGE_SHIFT, 9'd0, 32'h0000_0030, 1'b1, '0},
      // Windows of three: one window with two distinct pages, one with a single page
      // repeated, then a partial window at the end of the trace.
      '{ROW_CSR, CSR_WINDOW_LENGTH, 9'd3, 32'h0, 1'b0, '0},
      '{ROW_CSR, CSR_PAGE_SHIFT,    9'd8, 32'h0, 1'b0, '0},
      '{ROW_ACCESS, CSR_PAGE_SHIFT, 9'd0, 32'h0000_0100, 1'b0, '0},
      '{ROW_ACCESS, CSR_PAGE_SHIFT, 9'd0, 32'h0000_01FF, 1'b0, '0},
      '{ROW_ACCESS, CSR_PAGE_SHIFT, 9'd0, 32'h0000_0200, 1'b0, '0},
      '{ROW_ACCESS, CSR_PAGE_SHIFT, 9'd0, 32'h0000_0300, 1'b0, '0},
      '{ROW_ACCESS, CSR_PAGE_SHIFT, 9'd0, 32'h0000_0300, 1'b0, '0},
      '{ROW_ACCESS, CSR_PAGE_SHIFT, 9'd0, 32'h0000_0300, 1'b0, '0},
      '{ROW_ACCESS, CSR_PAGE_SHIFT, 9'd0, 32'h0000_0400, 1'b1, '0},
      // Back to the reset settings.
      '{ROW_CSR, CSR_WINDOW_LENGTH, 9'd16, 32'h0, 1'b0, '0},
      '{ROW_CSR, CSR_PAGE_SHIFT,    9'd12, 32'h0, 1'b0, '0}
   };

   logic                clock;
   logic                reset;
   logic                csr_we;
   csr_index_type       csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   logic                quiet;

   wswc_req_if req_if ();
   wswc_rsp_if rsp_if ();

   working_set_window_counter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // The model's copy of the registers, which follows every write.
   logic [SHIFT_W-1:0] cfg_shift  = PAGE_SHIFT_RESET;
   logic [CNT_W-1:0]   cfg_length = WINDOW_LENGTH_RESET;

   // The model's copy of the page set and the statistics. Pages are stored in order of
   // arrival, so the live part of the set is always the first ws_occupied entries.
   logic [PAGE_W-1:0]  ws_pages [WINDOW_MAX];
   int unsigned        ws_occupied;
   int unsigned        ws_accesses;
   int unsigned        ws_fewest;
   int unsigned        ws_most;
   logic [SUM_W-1:0]   ws_frames;
   logic [TALLY_W-1:0] ws_windows;

   window_report_type pending_reports [$];
   int unsigned       field_mismatches;
   int unsigned       accesses_sent;

   function automatic int unsigned effective_length(input logic [CNT_W-1:0] length);
      return (length == 0 || length > WINDOW_MAX) ? WINDOW_MAX : int'(length);
   endfunction

   function automatic void reset_statistics();
      ws_occupied = 0;
      ws_accesses = 0;
      ws_fewest   = NO_FULL_WINDOW;
      ws_most     = 0;
      ws_frames   = '0;
      ws_windows  = '0;
   endfunction

   // A window that closes, whether full or partial, goes into the saturating totals.
   function automatic void add_to_totals();
      logic [SUM_W:0] wide_sum;
      wide_sum  = {1'b0, ws_frames} + (SUM_W + 1)'(ws_occupied);
      ws_frames = wide_sum[SUM_W] ? SUM_MAX : wide_sum[SUM_W-1:0];
      if (ws_windows != TALLY_MAX)
         ws_windows = ws_windows + 1'b1;
   endfunction

   // Works out the response to one accepted beat and moves the model state on.
   function automatic window_report_type predict_access(input logic [PAGE_W-1:0] address,
                                                        input logic last);
      window_report_type report;
      logic [PAGE_W-1:0] page;
      logic seen_before;
      logic closed;
      int unsigned span;
      page        = address >> cfg_shift;
      span        = effective_length(cfg_length);
      seen_before = 1'b0;
      for (int i = 0; i < ws_occupied; i++)
         if (ws_pages[i] == page)
            seen_before = 1'b1;
      if (!seen_before && ws_occupied < WINDOW_MAX) begin
         ws_pages[ws_occupied] = page;
         ws_occupied++;
      end
      report.page_number    = page;
      report.distinct_pages = CNT_W'(ws_occupied);
      ws_accesses++;
      closed = (ws_accesses >= span);
      if (closed) begin
         if (ws_occupied > ws_most)
            ws_most = ws_occupied;
         if (ws_occupied < ws_fewest)
            ws_fewest = ws_occupied;
         add_to_totals();
         ws_occupied = 0;
         ws_accesses = 0;
      end
      if (last && !closed)
         add_to_totals();
      report.window_closed = closed;
      report.trace_closed  = last;
      report.fewest_pages  = CNT_W'(ws_fewest);
      report.most_pages    = CNT_W'(ws_most);
      report.frames_sum    = ws_frames;
      report.window_tally  = ws_windows;
      // The statistics are cleared only after the response has been formed.
      if (last)
         reset_statistics();
      return report;
   endfunction

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // A run that hangs in a handshake is stopped here.
   initial begin
      #(LIMIT_NS);
      $display("Test completed with failures");
      $finish;
   end

   task automatic check_field(input string name, input logic [63:0] actual,
                              input logic [63:0] wanted);
      if (actual !== wanted) begin
         field_mismatches++;
         if (field_mismatches <= MAX_REPORTS)
            $display("mismatch in %s: expected %0h, actual %0h", name, wanted, actual);
      end
   endtask

   // Response side: ready drops at random about one cycle in five, except in the quiet
   // stretch. Each beat taken is compared with the oldest expected response.
   always @(posedge clock) begin
      window_report_type seen;
      window_report_type wanted;
      rsp_if.ready <= quiet || ($urandom_range(0, 99) >= 19);
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         seen.page_number    = rsp_if.page_number;
         seen.window_closed  = rsp_if.window_closed;
         seen.trace_closed   = rsp_if.trace_closed;
         seen.distinct_pages = rsp_if.distinct_pages;
         seen.fewest_pages   = rsp_if.fewest_pages;
         seen.most_pages     = rsp_if.most_pages;
         seen.frames_sum     = rsp_if.frames_sum;
         seen.window_tally   = rsp_if.window_tally;
         if (pending_reports.size() == 0) begin
            field_mismatches++;
            if (field_mismatches <= MAX_REPORTS)
               $display("response beat with no request behind it, page %0h",
                        seen.page_number);
         end else begin
            wanted = pending_reports.pop_front();
            check_field("page_number",    seen.page_number,    wanted.page_number);
            check_field("window_closed",  seen.window_closed,  wanted.window_closed);
            check_field("trace_closed",   seen.trace_closed,   wanted.trace_closed);
            check_field("distinct_pages", seen.distinct_pages, wanted.distinct_pages);
            check_field("fewest_pages",   seen.fewest_pages,   wanted.fewest_pages);
            check_field("most_pages",     seen.most_pages,     wanted.most_pages);
            check_field("frames_sum",     seen.frames_sum,     wanted.frames_sum);
            check_field("window_tally",   seen.window_tally,   wanted.window_tally);
         end
      end
   end

   // Offers one request beat and returns at the edge where it is taken. Valid stays
   // high afterwards, so back-to-back beats need no extra assignment. The expected
   // response is queued on the falling edge before the handshake, once ready is known
   // to be high.
   task automatic send_access(input logic [PAGE_W-1:0] address, input logic last,
                              input logic typed, input window_report_type want);
      window_report_type predicted;
      quiet <= (accesses_sent >= QUIET_FROM && accesses_sent < QUIET_UNTIL);
      if (!quiet && $urandom_range(0, 99) < 19) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.address       <= address;
      req_if.last_of_trace <= last;
      @(negedge clock);
      while (!req_if.ready)
         @(negedge clock);
      predicted = predict_access(address, last);
      pending_reports.push_back(typed ? want : predicted);
      accesses_sent++;
      @(posedge clock);
   endtask

   // Brings the block to rest: no beat on offer, every response back, and then an
   // extra wait on the clock for the last access to settle.
   task automatic drain_block();
      req_if.valid <= 1'b0;
      while (pending_reports.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (index == CSR_PAGE_SHIFT)
         cfg_shift = data[SHIFT_W-1:0];
      else
         cfg_length = data;
   endtask

   initial begin
      logic [PAGE_W-1:0] pool [40];
      logic [PAGE_W-1:0] base;
      logic [PAGE_W-1:0] low_mask;
      logic [PAGE_W-1:0] address;
      logic              last;
      logic              noisy;
      int unsigned       pool_size;
      int unsigned       span;
      int unsigned       trace_beats;
      int unsigned       pick;

      reset_statistics();
      field_mismatches = 0;
      accesses_sent    = 0;

      reset                <= 1'b1;
      quiet                <= 1'b0;
      csr_we               <= 1'b0;
      csr_index            <= CSR_PAGE_SHIFT;
      csr_data             <= '0;
      req_if.valid         <= 1'b0;
      req_if.address       <= '0;
      req_if.last_of_trace <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table. Register rows wait for the block to come to rest first.
      foreach (DIRECTED_PLAN[r]) begin
         if (DIRECTED_PLAN[r].kind == ROW_CSR) begin
            drain_block();
            write_register(DIRECTED_PLAN[r].index, DIRECTED_PLAN[r].data);
         end else begin
            send_access(DIRECTED_PLAN[r].address, DIRECTED_PLAN[r].last,
                        DIRECTED_PLAN[r].kind == ROW_ACCESS_TYPED, DIRECTED_PLAN[r].want);
         end
      end

      // One window of the longest length in which every page is new. This fills the set
      // to the top and takes the most and fewest counts to their ceiling.
      drain_block();
      write_register(CSR_PAGE_SHIFT, CSR_DATA_W'(0));
      write_register(CSR_WINDOW_LENGTH, WINDOW_MAX_CNT);
      base = $urandom;
      for (int i = 0; i < WINDOW_MAX; i++)
         send_access(base + PAGE_W'(i), 1'b0, 1'b0, '0);
      for (int i = 0; i < 6; i++)
         send_access($urandom, i == 5, 1'b0, '0);

      // Random phases. Most traces revisit a small pool of pages, so that windows hold
      // repeats. Some are pure noise, and a few carry a stray last-of-trace mark in the
      // middle or end without one.
      while (accesses_sent < RANDOM_BEATS) begin
         drain_block();
         if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 9);
            write_register(CSR_PAGE_SHIFT, pick == 0 ? CSR_DATA_W'(0) :
                           pick == 1 ? CSR_DATA_W'(31) : CSR_DATA_W'($urandom_range(0, 31)));
         end
         if ($urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 5) == 0) begin
               pick = $urandom_range(0, 4);
               write_register(CSR_WINDOW_LENGTH,
                              pick == 0 ? CSR_DATA_W'(0) :
                              pick == 1 ? WINDOW_MAX_CNT :
                              pick == 2 ? CSR_DATA_W'($urandom_range(257, 511)) :
                              CSR_DATA_W'($urandom_range(25, 255)));
            end else begin
               write_register(CSR_WINDOW_LENGTH, CSR_DATA_W'($urandom_range(1, 24)));
            end
         end
         span     = effective_length(cfg_length);
         low_mask = (PAGE_W'(1) << cfg_shift) - 1'b1;
         repeat ($urandom_range(1, 3)) begin
            trace_beats = (span <= 24) ? $urandom_range(1, 4 * span + 3)
                                       : $urandom_range(span / 2, span + 12);
            pool_size   = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40)
                                                      : $urandom_range(1, 12);
            for (int i = 0; i < pool_size; i++)
               pool[i] = $urandom;
            noisy = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < trace_beats; k++) begin
               address = noisy ? PAGE_W'($urandom)
                               : pool[$urandom_range(0, pool_size - 1)] ^
                                 (PAGE_W'($urandom) & low_mask);
               last = (k == trace_beats - 1) ? ($urandom_range(0, 7) != 0)
                                             : ($urandom_range(0, 49) == 0);
               send_access(address, last, 1'b0, '0);
            end
         end
      end

      drain_block();
      repeat (12) @(posedge clock);
      if (field_mismatches == 0 && pending_reports.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
